### src/srtt_pkg.sv
// Shared types and constants for the signed radix to text converter.
package srtt_pkg;

	localparam int NUM_W       = 32;
	localparam int SYM_W       = 8;
	localparam int MAX_SYMBOLS = 16;
	localparam int SYM_IDX_W   = $clog2(MAX_SYMBOLS);
	localparam int SCNT_W      = 5;
	localparam int DIGIT_W     = 4;
	localparam int DIGIT_DEPTH = 32;
	localparam int IDX_W       = $clog2(DIGIT_DEPTH);
	localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);
	localparam int DIV_STEPS   = 8;
	localparam int DIV_CYCLES  = NUM_W / DIV_STEPS;
	localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);
	localparam int REM_W       = DIGIT_W + 1;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;

	typedef logic [MAX_SYMBOLS-1:0][SYM_W-1:0] alphabet_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHABET_LOW  = 2'd0,
		REG_ALPHABET_HIGH = 2'd1,
		REG_SYMBOL_COUNT  = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_BAD,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic               go;
		logic [NUM_W-1:0]   dividend;
		logic [SCNT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [NUM_W-1:0]   quotient;
		logic [DIGIT_W-1:0] remainder;
	} div_rsp_t;

endpackage

### src/srtt_divider.sv
// Iterative divider that retires several quotient bits per cycle.
module srtt_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  srtt_pkg::div_req_t req,
	output srtt_pkg::div_rsp_t rsp
);
	import srtt_pkg::*;

	logic                 active_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     dq_q;
	logic [REM_W-1:0]     rem_q;
	logic [SCNT_W-1:0]    div_q;
	logic [NUM_W-1:0]     dq_d;
	logic [REM_W-1:0]     rem_d;

	always_comb begin
		logic [REM_W-1:0] trial;
		dq_d  = dq_q;
		rem_d = rem_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {rem_d[DIGIT_W-1:0], dq_d[NUM_W-1]};
			dq_d  = {dq_d[NUM_W-2:0], 1'b0};
			if (trial >= div_q) begin
				rem_d    = trial - div_q;
				dq_d[0]  = 1'b1;
			end else begin
				rem_d = trial;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			dq_q  <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (active_q) begin
			dq_q  <= dq_d;
			rem_q <= rem_d;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dq_q;
	assign rsp.remainder = rem_q[DIGIT_W-1:0];

endmodule

### src/srtt_ctrl.sv
// Sequencer: alphabet check, digit generation into the digit store, and text output.
module srtt_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [srtt_pkg::NUM_W-1:0] number,
	input  srtt_pkg::alphabet_t           alphabet,
	input  logic [srtt_pkg::SCNT_W-1:0]   symbol_count,
	output logic                          busy,
	output logic                          strobe,
	output logic [srtt_pkg::SYM_W-1:0]    symbol,
	output logic                          is_last,
	output logic                          alphabet_invalid,
	output srtt_pkg::div_req_t            div_req,
	input  srtt_pkg::div_rsp_t            div_rsp
);
	import srtt_pkg::*;

	state_t               state_q, state_d;
	logic                 neg_q;
	logic [NUM_W-1:0]     mag_q;
	logic [SYM_IDX_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0]     pos_q, pos_d;
	logic [DIGIT_W-1:0]   mem [DIGIT_DEPTH];
	logic [DIGIT_W-1:0]   rd_q;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_en;
	logic                 strobe_d, last_d, bad_d;
	logic [SYM_W-1:0]     symbol_d;
	logic                 strobe_q, last_q, bad_q;
	logic [SYM_W-1:0]     symbol_q;
	logic [NUM_W-1:0]     num_u;
	logic                 count_bad;
	logic                 sym_bad;
	logic [SYM_W-1:0]     code;

	assign num_u     = number;
	assign count_bad = (symbol_count < SCNT_W'(2)) || (symbol_count > SCNT_W'(MAX_SYMBOLS));
	assign code      = alphabet[idx_q];
	assign wr_en     = (state_q == ST_DIV) && div_rsp.done && (pos_q < CNT_W'(DIGIT_DEPTH));

	always_comb begin
		sym_bad = (code == SIGN_PLUS) || (code == SIGN_MINUS);
		for (int j = 0; j < MAX_SYMBOLS; j++) begin
			if ((SYM_IDX_W'(j) < idx_q) && (alphabet[j] == code)) begin
				sym_bad = 1'b1;
			end
		end
	end

	always_comb begin
		state_d          = state_q;
		idx_d            = idx_q;
		pos_d            = pos_q;
		div_req.go       = 1'b0;
		div_req.dividend = mag_q;
		div_req.divisor  = symbol_count;
		rd_addr          = IDX_W'(pos_q - CNT_W'(1));
		strobe_d         = 1'b0;
		last_d           = 1'b0;
		bad_d            = 1'b0;
		symbol_d         = '0;
		unique case (state_q)
			ST_IDLE: begin
				idx_d = '0;
				pos_d = '0;
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (count_bad || sym_bad) begin
					state_d = ST_BAD;
				end else if (idx_q == SYM_IDX_W'(symbol_count - SCNT_W'(1))) begin
					div_req.go = 1'b1;
					state_d    = ST_DIV;
				end else begin
					idx_d = idx_q + SYM_IDX_W'(1);
				end
			end
			ST_BAD: begin
				strobe_d = 1'b1;
				last_d   = 1'b1;
				bad_d    = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					if (pos_q < CNT_W'(DIGIT_DEPTH)) begin
						pos_d = pos_q + CNT_W'(1);
					end
					if (div_rsp.quotient == '0) begin
						state_d = ST_SIGN;
					end else begin
						div_req.go       = 1'b1;
						div_req.dividend = div_rsp.quotient;
					end
				end
			end
			ST_SIGN: begin
				rd_addr = IDX_W'(pos_q - CNT_W'(1));
				if (neg_q) begin
					strobe_d = 1'b1;
					symbol_d = SIGN_MINUS;
				end
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				rd_addr  = IDX_W'(pos_q - CNT_W'(2));
				strobe_d = 1'b1;
				symbol_d = alphabet[rd_q];
				pos_d    = pos_q - CNT_W'(1);
				if (pos_q == CNT_W'(1)) begin
					last_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			pos_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			pos_q    <= pos_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		last_q   <= last_d;
		bad_q    <= bad_d;
		symbol_q <= symbol_d;
		if (state_q == ST_IDLE && start) begin
			neg_q <= num_u[NUM_W-1];
			mag_q <= num_u[NUM_W-1] ? (~num_u + NUM_W'(1)) : num_u;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q[IDX_W-1:0]] <= div_rsp.remainder;
		end
		rd_q <= mem[rd_addr];
	end

	assign busy             = (state_q != ST_IDLE);
	assign strobe           = strobe_q;
	assign symbol           = symbol_q;
	assign is_last          = last_q;
	assign alphabet_invalid = bad_q;

endmodule

### src/signed_radix_to_text.sv
// Top level of the signed radix to text converter with its configuration registers.
// A number is taken when start is high and busy is low; the block then checks the
// alphabet (one symbol per cycle), divides the magnitude by the radix in a single
// divider used for every digit, and emits one word per cycle: an optional minus
// sign, then the digits most significant first. A rejected alphabet returns the
// block to idle. The last word shows in the first cycle with busy low. Each word is
// shown for exactly one cycle with strobe high and cannot be held off; is_last marks
// the final word, and a rejected alphabet gives a single word with alphabet_invalid
// set. Configuration writes are always accepted and must be made while the block is
// idle.
module signed_radix_to_text (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [srtt_pkg::NUM_W-1:0] number,
	output logic                              strobe,
	output logic [srtt_pkg::SYM_W-1:0]        symbol,
	output logic                              is_last,
	output logic                              alphabet_invalid,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [srtt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [srtt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import srtt_pkg::*;

	logic [CFG_DATA_W-1:0] alphabet_low_q;
	logic [CFG_DATA_W-1:0] alphabet_high_q;
	logic [SCNT_W-1:0]     symbol_count_q;
	alphabet_t             alphabet;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	assign cfg_ready = 1'b1;
	assign alphabet  = {alphabet_high_q, alphabet_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_low_q  <= '0;
			alphabet_high_q <= '0;
			symbol_count_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ALPHABET_LOW:  alphabet_low_q  <= cfg_data;
				REG_ALPHABET_HIGH: alphabet_high_q <= cfg_data;
				REG_SYMBOL_COUNT:  symbol_count_q  <= cfg_data[SCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	srtt_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.number           (number),
		.alphabet         (alphabet),
		.symbol_count     (symbol_count_q),
		.busy             (busy),
		.strobe           (strobe),
		.symbol           (symbol),
		.is_last          (is_last),
		.alphabet_invalid (alphabet_invalid),
		.div_req          (div_req),
		.div_rsp          (div_rsp)
	);

	srtt_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

### src/srtt_checker.sv
// Port-level assertions for the signed radix to text converter and their binding.
module srtt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       strobe,
	input logic [srtt_pkg::SYM_W-1:0] symbol,
	input logic                       is_last,
	input logic                       alphabet_invalid
);
	import srtt_pkg::*;

	a_invalid_alone: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && alphabet_invalid |-> is_last && (symbol == '0))
		else $error("Rejected alphabet word is not a lone zero word.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted number did not make the block busy.");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && is_last |=> !strobe)
		else $error("Word follows directly after the last word of a number.");

	a_mid_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_last |-> busy)
		else $error("Word before the last one appeared while idle.");

endmodule

bind signed_radix_to_text srtt_checker u_srtt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.strobe           (strobe),
	.symbol           (symbol),
	.is_last          (is_last),
	.alphabet_invalid (alphabet_invalid)
);
